// ===== design/edfadm_pkg.sv =====
// shared types, codes and widths for the edf admission unit
package edfadm_pkg;

   localparam int TIME_W    = 16;
   localparam int ID_W      = 8;
   localparam int LEVEL_W   = 16;
   localparam int LIU_W     = 3;
   localparam int STATUS_W  = 3;
   localparam int SPD_W     = 3;
   localparam int HELD_W    = 5;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int LVL_FRAC  = 15;

   typedef enum logic [STATUS_W-1:0] {
      STAT_ACCEPT   = 3'd0,
      STAT_OVERLOAD = 3'd1,
      STAT_FULL     = 3'd2,
      STAT_BAD_DL   = 3'd3,
      STAT_EXEC     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_AK,
      S_AKD,
      S_ASW,
      S_ASWL,
      S_AMUL,
      S_ACMP,
      S_ASPD,
      S_AUPD,
      S_XSW,
      S_XSWL,
      S_XUPD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] remaining;
      logic [ID_W-1:0]   task_id;
   } entry_type;

endpackage

// ===== design/edfadm_req_if.sv =====
// request channel of the edf admission unit
interface edfadm_req_if import edfadm_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [TIME_W-1:0] now;
   logic [ID_W-1:0]   task_id;
   logic [TIME_W-1:0] deadline;
   logic [TIME_W-1:0] work;

   modport source (output valid, mode, now, task_id, deadline, work, input ready);
   modport sink (input valid, mode, now, task_id, deadline, work, output ready);
endinterface

// ===== design/edfadm_rsp_if.sv =====
// response channel of the edf admission unit
interface edfadm_rsp_if import edfadm_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SPD_W-1:0]    speed_index;
   logic                ran_valid;
   logic [ID_W-1:0]     ran_task;
   logic                ran_finished;
   logic [HELD_W-1:0]   tasks_held;

   modport source (output valid, status, speed_index, ran_valid, ran_task, ran_finished,
                   tasks_held, input ready);
   modport sink (input valid, status, speed_index, ran_valid, ran_task, ran_finished,
                 tasks_held, output ready);
endinterface

// ===== design/edfadm_csr_if.sv =====
// register write channel of the edf admission unit
interface edfadm_csr_if import edfadm_pkg::*; ;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== design/edf_admission_with_speed_select_unit.sv =====
// edf admission test with speed level selection over a slot memory
//
//  channel   dir  payload
//  req_ch    in   mode, now, task_id, deadline, work
//  rsp_ch    out  status, speed_index, ran_valid, ran_task, ran_finished, tasks_held
//  csr_ch    in   index, data (always ready)
//
// admission: one deadline read per held task; for each held task whose deadline lies
// ahead, and for the new one, a sweep of TASK_SLOTS reads of the single-port slot memory,
// then multiply and compare
// execute: one sweep of the slot memory
// reset clears valid bits and control registers, no memory clearing pass
// one request at a time; a finished response waits in the output register
module edf_admission_with_speed_select_unit import edfadm_pkg::*; #(
   parameter int TASK_SLOTS   = 16,
   parameter int SPEED_LEVELS = 4
) (
   input  logic          clock,
   input  logic          reset,
   edfadm_req_if.sink    req_ch,
   edfadm_rsp_if.source  rsp_ch,
   edfadm_csr_if.sink    csr_ch
);

   localparam int SLOT_W = $clog2(TASK_SLOTS);
   localparam int K_W    = $clog2(TASK_SLOTS + 1);
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
   localparam int SUM_W  = TIME_W + $clog2(TASK_SLOTS + 1);
   localparam int PRD_W  = SUM_W + TIME_W;
   localparam int LV_W   = $clog2(SPEED_LEVELS + 1);
   localparam int LI_W   = (SPEED_LEVELS > 1) ? $clog2(SPEED_LEVELS) : 1;
   localparam int CMP_W  = SUM_W + LVL_FRAC + 1;

   entry_type mem [TASK_SLOTS];

   state_type state_ff, state_in;

   logic [TASK_SLOTS-1:0] valid_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [LEVEL_W-1:0]    level_ff [SPEED_LEVELS];
   logic [LIU_W-1:0]      liu_ff;

   logic              mode_ff;
   logic [TIME_W-1:0] now_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] dl_ff;
   logic [TIME_W-1:0] wk_ff;

   logic [K_W-1:0]    k_ff;
   logic [SLOT_W-1:0] j_ff;
   logic [TIME_W-1:0] dk_ff;
   logic [TIME_W-1:0] dd_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  bn_ff;
   logic [TIME_W-1:0] bd_ff;
   logic              inf_ff;
   logic [PRD_W-1:0]  p1_ff;
   logic [PRD_W-1:0]  p2_ff;
   logic [LV_W-1:0]   li_ff;
   logic [LV_W-1:0]   spd_ff;

   logic              found_ff;
   logic [SLOT_W-1:0] bi_ff;
   logic [TIME_W-1:0] bdl_ff;
   logic [TIME_W-1:0] brem_ff;
   logic [ID_W-1:0]   bid_ff;

   logic [STATUS_W-1:0] status_ff;
   logic                rv_ff;
   logic                rf_ff;
   logic [ID_W-1:0]     rt_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SPD_W-1:0]    rsp_spd_ff;
   logic                rsp_rv_ff;
   logic [ID_W-1:0]     rsp_rt_ff;
   logic                rsp_rf_ff;
   logic [HELD_W-1:0]   rsp_held_ff;

   logic              rd_en;
   logic [SLOT_W-1:0] rd_addr;
   entry_type         rdata_ff;
   logic              rdv_ff;
   logic [SLOT_W-1:0] rdi_ff;
   logic              we;
   logic [SLOT_W-1:0] wa;
   entry_type         wd;

   logic              req_acc;
   logic              full;
   logic [SLOT_W-1:0] free_slot;
   logic              k_last;
   logic              j_last;
   logic [3:0]        lim;
   logic              lvl_hit;
   logic              admit_ok;
   logic [TIME_W-1:0] new_rem;
   logic              rsp_free;
   logic              sw_hit;

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign full     = &valid_ff;
   assign k_last   = (k_ff == K_W'(TASK_SLOTS));
   assign j_last   = (j_ff == SLOT_W'(TASK_SLOTS - 1));
   assign lim      = ({1'b0, liu_ff} > 4'(SPEED_LEVELS)) ? 4'(SPEED_LEVELS) : {1'b0, liu_ff};
   assign lvl_hit  = (CMP_W'(level_ff[li_ff[LI_W-1:0]]) * CMP_W'(bd_ff)) >
                     CMP_W'({bn_ff, 15'd0});
   assign admit_ok = !inf_ff && (bn_ff <= SUM_W'(bd_ff));
   assign new_rem  = (brem_ff == '0) ? '0 : brem_ff - 1'b1;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign sw_hit   = rdv_ff && valid_ff[rdi_ff] && (rdata_ff.deadline <= dk_ff);

   always_comb begin
      free_slot = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_slot = SLOT_W'(i);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_ch.mode) state_in = S_XSW;
               else if (req_ch.deadline <= req_ch.now || full) state_in = S_DONE;
               else state_in = S_AK;
            end
         end
         S_AK: begin
            if (k_last) state_in = S_ASW;
            else if (valid_ff[k_ff[SLOT_W-1:0]]) state_in = S_AKD;
         end
         S_AKD: state_in = (rdata_ff.deadline <= now_ff) ? S_AK : S_ASW;
         S_ASW: if (j_last) state_in = S_ASWL;
         S_ASWL: state_in = S_AMUL;
         S_AMUL: state_in = S_ACMP;
         S_ACMP: state_in = k_last ? S_ASPD : S_AK;
         S_ASPD: begin
            if (inf_ff || 4'(li_ff) >= lim || lvl_hit) state_in = S_AUPD;
         end
         S_AUPD: state_in = S_DONE;
         S_XSW: if (j_last) state_in = S_XSWL;
         S_XSWL: state_in = S_XUPD;
         S_XUPD: state_in = S_DONE;
         S_DONE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = j_ff;
      we      = 1'b0;
      wa      = free_slot;
      wd      = '{deadline: dl_ff, remaining: wk_ff, task_id: id_ff};
      unique case (state_ff)
         S_AK: begin
            rd_addr = k_ff[SLOT_W-1:0];
            rd_en   = !k_last && valid_ff[k_ff[SLOT_W-1:0]];
         end
         S_ASW, S_XSW: rd_en = 1'b1;
         S_AUPD: we = admit_ok;
         S_XUPD: begin
            we = found_ff;
            wa = bi_ff;
            wd = '{deadline: bdl_ff, remaining: new_rem, task_id: bid_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[rd_addr];
      if (we) mem[wa] <= wd;
      rdi_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         liu_ff       <= LIU_W'(4);
         for (int i = 0; i < SPEED_LEVELS; i++) level_ff[i] <= LEVEL_W'(32768);
      end else begin
         state_ff <= state_in;
         rdv_ff   <= rd_en;
         if (csr_ch.valid) begin
            if (csr_ch.index < CSR_IDX_W'(SPEED_LEVELS))
               level_ff[csr_ch.index[LI_W-1:0]] <= csr_ch.data;
            else if (csr_ch.index == CSR_IDX_W'(SPEED_LEVELS))
               liu_ff <= csr_ch.data[LIU_W-1:0];
         end
         if (state_ff == S_AUPD && admit_ok) begin
            valid_ff[free_slot] <= 1'b1;
            count_ff            <= count_ff + 1'b1;
         end
         if (state_ff == S_XUPD && found_ff && new_rem == '0) begin
            valid_ff[bi_ff] <= 1'b0;
            count_ff        <= count_ff - 1'b1;
         end
         if (state_ff == S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            mode_ff   <= req_ch.mode;
            now_ff    <= req_ch.now;
            id_ff     <= req_ch.task_id;
            dl_ff     <= req_ch.deadline;
            wk_ff     <= req_ch.work;
            k_ff      <= '0;
            j_ff      <= '0;
            bn_ff     <= '0;
            bd_ff     <= TIME_W'(1);
            inf_ff    <= 1'b0;
            found_ff  <= 1'b0;
            rv_ff     <= 1'b0;
            rf_ff     <= 1'b0;
            rt_ff     <= '0;
            spd_ff    <= '0;
            status_ff <= (req_ch.deadline <= req_ch.now) ? STAT_BAD_DL : STAT_FULL;
         end
         S_AK: begin
            if (k_last) begin
               dk_ff  <= dl_ff;
               sum_ff <= SUM_W'(wk_ff);
               j_ff   <= '0;
            end else if (!valid_ff[k_ff[SLOT_W-1:0]]) begin
               k_ff <= k_ff + 1'b1;
            end
         end
         S_AKD: begin
            dk_ff  <= rdata_ff.deadline;
            j_ff   <= '0;
            sum_ff <= (dl_ff <= rdata_ff.deadline) ? SUM_W'(wk_ff) : '0;
            if (rdata_ff.deadline <= now_ff) begin
               inf_ff <= 1'b1;
               k_ff   <= k_ff + 1'b1;
            end
         end
         S_ASW, S_ASWL: begin
            if (state_ff == S_ASW) j_ff <= j_ff + 1'b1;
            if (sw_hit) sum_ff <= sum_ff + SUM_W'(rdata_ff.remaining);
         end
         S_AMUL: begin
            p1_ff <= PRD_W'(sum_ff) * PRD_W'(bd_ff);
            p2_ff <= PRD_W'(bn_ff) * PRD_W'(dk_ff - now_ff);
            dd_ff <= dk_ff - now_ff;
         end
         S_ACMP: begin
            if (p1_ff > p2_ff) begin
               bn_ff <= sum_ff;
               bd_ff <= dd_ff;
            end
            k_ff   <= k_ff + 1'b1;
            li_ff  <= '0;
            spd_ff <= LV_W'(SPEED_LEVELS);
         end
         S_ASPD: begin
            if (!inf_ff && 4'(li_ff) < lim) begin
               if (lvl_hit) spd_ff <= li_ff;
               else li_ff <= li_ff + 1'b1;
            end
         end
         S_AUPD: status_ff <= admit_ok ? STAT_ACCEPT : STAT_OVERLOAD;
         S_XSW, S_XSWL: begin
            if (state_ff == S_XSW) j_ff <= j_ff + 1'b1;
            if (rdv_ff && valid_ff[rdi_ff] &&
                (!found_ff || rdata_ff.deadline < bdl_ff)) begin
               found_ff <= 1'b1;
               bi_ff    <= rdi_ff;
               bdl_ff   <= rdata_ff.deadline;
               brem_ff  <= rdata_ff.remaining;
               bid_ff   <= rdata_ff.task_id;
            end
         end
         S_XUPD: begin
            status_ff <= STAT_EXEC;
            rv_ff     <= found_ff;
            rt_ff     <= found_ff ? bid_ff : '0;
            rf_ff     <= found_ff && (new_rem == '0);
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_status_ff <= status_ff;
               rsp_spd_ff    <= SPD_W'(spd_ff);
               rsp_rv_ff     <= rv_ff;
               rsp_rt_ff     <= rt_ff;
               rsp_rf_ff     <= rf_ff;
               rsp_held_ff   <= HELD_W'(count_ff);
            end
         end
         default: ;
      endcase
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.speed_index = rsp_spd_ff;
   assign rsp_ch.ran_valid   = rsp_rv_ff;
   assign rsp_ch.ran_task    = rsp_rt_ff;
   assign rsp_ch.ran_finished = rsp_rf_ff;
   assign rsp_ch.tasks_held  = rsp_held_ff;

`ifndef SYNTH
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("held count out of step with valid bits");

   a_ran_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rv_ff |-> rsp_status_ff == STAT_EXEC)
      else $error("ran task reported outside execute");

   a_no_admit_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_AUPD |-> !mode_ff)
      else $error("admission update in execute request");

   a_spd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_ACCEPT && rsp_status_ff != STAT_OVERLOAD
      |-> rsp_spd_ff == '0)
      else $error("speed index set without admission test");
`endif

endmodule
